// ----- rtl/pnm_image_stream_parser_top_macros.svh -----
// assertion macros used by the parser's job queue
`ifndef PNM_IMAGE_STREAM_PARSER_TOP_MACROS_SVH
`define PNM_IMAGE_STREAM_PARSER_TOP_MACROS_SVH

// property checked outside reset
`define PNM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define PNM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/pnm_pkg.sv -----
`timescale 1ns / 1ps

package pnm_pkg;

    localparam int DIM_BITS = 16;
    localparam logic [16:0] DIM_LIMIT = 17'((64'd1 << DIM_BITS) - 64'd1);
    localparam logic [16:0] MAXVAL_LIMIT = 17'd65535;
    localparam int QDEPTH = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_ONE  = 8'd49;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_SEVEN = 8'd55;

    localparam logic [2:0] FMT_PBM_PLAIN = 3'd1;
    localparam logic [2:0] FMT_PPM_PLAIN = 3'd3;
    localparam logic [2:0] FMT_PBM_RAW   = 3'd4;
    localparam logic [2:0] FMT_PGM_RAW   = 3'd5;
    localparam logic [2:0] FMT_PPM_RAW   = 3'd6;

    typedef enum logic [1:0] {
        RK_HEADER = 2'd0,
        RK_SAMPLE = 2'd1,
        RK_ERROR  = 2'd2
    } rk_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_NO_P      = 4'd1,
        ERR_DIGIT     = 4'd2,
        ERR_NO_SPACE  = 4'd3,
        ERR_NUMBER    = 4'd4,
        ERR_BIT       = 4'd5,
        ERR_OVER_MAX  = 4'd6,
        ERR_NO_SEP    = 4'd7,
        ERR_TOO_LARGE = 4'd8,
        ERR_EARLY_END = 4'd9
    } err_t;

    // parser phases: magic, format digit, then separator, skip, number for width, height, maximum, then raster
    typedef enum logic [3:0] {
        PH_MAGIC  = 4'd0,
        PH_DIGIT  = 4'd1,
        PH_W_SEP  = 4'd2,
        PH_W_SKIP = 4'd3,
        PH_W_NUM  = 4'd4,
        PH_H_SEP  = 4'd5,
        PH_H_SKIP = 4'd6,
        PH_H_NUM  = 4'd7,
        PH_M_SEP  = 4'd8,
        PH_M_SKIP = 4'd9,
        PH_M_NUM  = 4'd10,
        PH_RASTER = 4'd11
    } ph_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
        logic       restart;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  format_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_sample;
        logic [15:0] sample_value;
        logic [15:0] column;
        logic [15:0] row;
        logic [1:0]  channel;
        logic [3:0]  error_code;
        logic        end_of_image;
        logic        last_of_run;
    } result_t;

    // one queued job: a single result, or a run of raw bitmap bits
    typedef struct packed {
        rk_t         kind;
        err_t        err;
        logic [2:0]  fmt;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] maxval;
        logic [15:0] value;
        logic [15:0] col;
        logic [15:0] row;
        logic [1:0]  ch;
        logic        eoi;
        logic        is_bits;
        logic [7:0]  bits;
        logic [2:0]  last_idx;
    } dsc_t;

    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic [1:0]  ch;
        logic        eoi;
        logic        done;
    } pos_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [1:0] ph_field(input ph_t ph);
        logic [1:0] f;
        unique case (ph)
            PH_H_SEP, PH_H_SKIP, PH_H_NUM: f = 2'd1;
            PH_M_SEP, PH_M_SKIP, PH_M_NUM: f = 2'd2;
            default:                       f = 2'd0;
        endcase
        return f;
    endfunction

    function automatic logic [1:0] ph_sub(input ph_t ph);
        logic [1:0] s;
        unique case (ph)
            PH_W_SKIP, PH_H_SKIP, PH_M_SKIP: s = 2'd1;
            PH_W_NUM, PH_H_NUM, PH_M_NUM:    s = 2'd2;
            default:                         s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic ph_t ph_make(input logic [1:0] f, input logic [1:0] s);
        return ph_t'(4'(4'd2 + 4'd3 * {2'd0, f} + {2'd0, s}));
    endfunction

    // position after one sample
    function automatic pos_t pos_advance(input logic [15:0] col, input logic [15:0] row,
                                         input logic [1:0] ch, input logic [1:0] spp,
                                         input logic [15:0] w, input logic [15:0] h);
        pos_t p;
        logic [16:0] c1;
        logic [16:0] r1;
        logic [2:0] h1;
        c1 = {1'b0, col} + 17'd1;
        r1 = {1'b0, row} + 17'd1;
        h1 = {1'b0, ch} + 3'd1;
        p.eoi = (h1 >= {1'b0, spp}) && (c1 >= {1'b0, w}) && (r1 >= {1'b0, h});
        p.col = col;
        p.row = row;
        p.ch = ch;
        p.done = 1'b0;
        if (h1 >= {1'b0, spp})
        begin
            p.ch = 2'd0;
            p.col = c1[15:0];
            if (c1 >= {1'b0, w})
            begin
                p.col = 16'd0;
                p.row = r1[15:0];
                if (r1 >= {1'b0, h})
                begin
                    p.done = 1'b1;
                end
            end
        end
        else
        begin
            p.ch = h1[1:0];
        end
        return p;
    endfunction

endpackage

// ----- rtl/pnm_front.sv -----
`timescale 1ns / 1ps

module pnm_front
    import pnm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  take,
    input  item_t item,
    output logic  push,
    output dsc_t  rec
);

    ph_t         phase_reg, phase_next;
    logic [2:0]  fmt_reg, fmt_next;
    logic [15:0] w_reg, w_next, h_reg, h_next, m_reg, m_next;
    logic [15:0] acc_reg, acc_next;
    logic        ds_reg, ds_next, cm_reg, cm_next;
    logic [15:0] col_reg, col_next, row_reg, row_next;
    logic [1:0]  ch_reg, ch_next;
    logic [8:0]  pend_reg, pend_next;
    err_t        err_reg, err_next;

    logic [7:0]  b;
    logic [19:0] mac;
    logic [1:0]  fld, sub, spp;
    logic        put, go, emit_req, last_hdr;
    logic [15:0] emit_val, v;
    logic [16:0] rem, ncol;
    logic [3:0]  nbits;
    pos_t        p;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            fmt_reg   <= 3'd0;
            w_reg     <= 16'd0;
            h_reg     <= 16'd0;
            m_reg     <= 16'd0;
            acc_reg   <= 16'd0;
            ds_reg    <= 1'b0;
            cm_reg    <= 1'b0;
            col_reg   <= 16'd0;
            row_reg   <= 16'd0;
            ch_reg    <= 2'd0;
            pend_reg  <= 9'd0;
            err_reg   <= ERR_NONE;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            fmt_reg   <= fmt_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            m_reg     <= m_next;
            acc_reg   <= acc_next;
            ds_reg    <= ds_next;
            cm_reg    <= cm_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            ch_reg    <= ch_next;
            pend_reg  <= pend_next;
            err_reg   <= err_next;
        end
    end

    assign push = take && put;

    // classify one byte and work out the job it causes
    always_comb
    begin
        phase_next = phase_reg;
        fmt_next   = fmt_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        m_next     = m_reg;
        acc_next   = acc_reg;
        ds_next    = ds_reg;
        cm_next    = cm_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        ch_next    = ch_reg;
        pend_next  = pend_reg;
        err_next   = err_reg;
        put        = 1'b0;
        rec        = '0;
        rec.kind   = RK_HEADER;
        rec.err    = ERR_NONE;
        emit_req   = 1'b0;
        emit_val   = 16'd0;
        v          = 16'd0;
        go         = 1'b0;
        last_hdr   = 1'b0;
        rem        = 17'd0;
        ncol       = 17'd0;
        nbits      = 4'd0;
        p          = '0;
        b          = item.data_byte;
        mac = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {16'd0, b[3:0]};
        fld = ph_field(phase_reg);
        sub = ph_sub(phase_reg);
        spp = ((fmt_reg == FMT_PPM_PLAIN) || (fmt_reg == FMT_PPM_RAW)) ? 2'd3 : 2'd1;

        if (item.restart)
        begin
            phase_next = PH_MAGIC;
            fmt_next   = 3'd0;
            w_next     = 16'd0;
            h_next     = 16'd0;
            m_next     = 16'd0;
            acc_next   = 16'd0;
            ds_next    = 1'b0;
            cm_next    = 1'b0;
            col_next   = 16'd0;
            row_next   = 16'd0;
            ch_next    = 2'd0;
            pend_next  = 9'd0;
            err_next   = ERR_NONE;
        end
        else if (err_reg == ERR_NONE)
        begin
            if (phase_reg == PH_RASTER)
            begin
                // raster bytes
                if (fmt_reg == FMT_PBM_RAW)
                begin
                    rem   = {1'b0, w_reg} - {1'b0, col_reg};
                    nbits = (rem >= 17'd8) ? 4'd8 : rem[3:0];
                    ncol  = {1'b0, col_reg} + {13'd0, nbits};
                    put          = 1'b1;
                    rec.kind     = RK_SAMPLE;
                    rec.is_bits  = 1'b1;
                    rec.bits     = b;
                    rec.col      = col_reg;
                    rec.row      = row_reg;
                    rec.last_idx = 3'(nbits - 4'd1);
                    rec.eoi = (ncol >= {1'b0, w_reg})
                              && (({1'b0, row_reg} + 17'd1) >= {1'b0, h_reg});
                    if (ncol >= {1'b0, w_reg})
                    begin
                        col_next = 16'd0;
                        row_next = row_reg + 16'd1;
                        if (({1'b0, row_reg} + 17'd1) >= {1'b0, h_reg})
                        begin
                            phase_next = PH_MAGIC;
                            col_next   = 16'd0;
                            row_next   = 16'd0;
                            ch_next    = 2'd0;
                            ds_next    = 1'b0;
                            acc_next   = 16'd0;
                            pend_next  = 9'd0;
                        end
                    end
                    else
                    begin
                        col_next = ncol[15:0];
                    end
                end
                else if (fmt_reg >= FMT_PGM_RAW)
                begin
                    go = 1'b1;
                    if (m_reg < 16'd256)
                    begin
                        v = {8'd0, b};
                    end
                    else if (pend_reg[8])
                    begin
                        v = {pend_reg[7:0], b};
                        pend_next = 9'd0;
                    end
                    else
                    begin
                        pend_next = {1'b1, b};
                        go = 1'b0;
                    end
                    if (go)
                    begin
                        if (v > m_reg)
                        begin
                            err_next = ERR_OVER_MAX;
                            put = 1'b1;
                            rec.kind = RK_ERROR;
                            rec.err = ERR_OVER_MAX;
                        end
                        else
                        begin
                            emit_req = 1'b1;
                            emit_val = v;
                        end
                    end
                end
                else
                begin
                    go = 1'b1;
                    if (cm_reg)
                    begin
                        if (b != CH_LF)
                        begin
                            go = 1'b0;
                        end
                        else
                        begin
                            cm_next = 1'b0;
                        end
                    end
                    if (go && (fmt_reg == FMT_PBM_PLAIN))
                    begin
                        if (is_ws(b))
                        begin
                            go = 1'b0;
                        end
                        else if (b == CH_HASH)
                        begin
                            cm_next = 1'b1;
                        end
                        else if ((b == CH_ZERO) || (b == CH_ONE))
                        begin
                            emit_req = 1'b1;
                            emit_val = {15'd0, b[0]};
                        end
                        else
                        begin
                            err_next = ERR_BIT;
                            put = 1'b1;
                            rec.kind = RK_ERROR;
                            rec.err = ERR_BIT;
                        end
                    end
                    else if (go)
                    begin
                        if (is_digit(b))
                        begin
                            acc_next = mac[15:0];
                            ds_next = 1'b1;
                            if (mac > {4'd0, m_reg})
                            begin
                                err_next = ERR_OVER_MAX;
                                put = 1'b1;
                                rec.kind = RK_ERROR;
                                rec.err = ERR_OVER_MAX;
                            end
                        end
                        else if (ds_reg)
                        begin
                            if (is_ws(b) || (b == CH_HASH))
                            begin
                                acc_next = 16'd0;
                                ds_next = 1'b0;
                                if (b == CH_HASH)
                                begin
                                    cm_next = 1'b1;
                                end
                                emit_req = 1'b1;
                                emit_val = acc_reg;
                            end
                            else
                            begin
                                err_next = ERR_NO_SEP;
                                put = 1'b1;
                                rec.kind = RK_ERROR;
                                rec.err = ERR_NO_SEP;
                            end
                        end
                        else if (b == CH_HASH)
                        begin
                            cm_next = 1'b1;
                        end
                        else if (!is_ws(b))
                        begin
                            err_next = ERR_NUMBER;
                            put = 1'b1;
                            rec.kind = RK_ERROR;
                            rec.err = ERR_NUMBER;
                        end
                    end
                end
            end
            else if (sub == 2'd2)
            begin
                // digits of a header number
                if (is_digit(b))
                begin
                    acc_next = mac[15:0];
                    if (mac > {3'd0, ((fld < 2'd2) ? DIM_LIMIT : MAXVAL_LIMIT)})
                    begin
                        err_next = ERR_TOO_LARGE;
                        put = 1'b1;
                        rec.kind = RK_ERROR;
                        rec.err = ERR_TOO_LARGE;
                    end
                end
                else
                begin
                    acc_next = 16'd0;
                    go = 1'b1;
                    if (fld == 2'd0)
                    begin
                        w_next = acc_reg;
                    end
                    else if (fld == 2'd1)
                    begin
                        h_next = acc_reg;
                    end
                    else if (acc_reg == 16'd0)
                    begin
                        go = 1'b0;
                        err_next = ERR_NUMBER;
                        put = 1'b1;
                        rec.kind = RK_ERROR;
                        rec.err = ERR_NUMBER;
                    end
                    else
                    begin
                        m_next = acc_reg;
                    end
                    last_hdr = ((fmt_reg == FMT_PBM_PLAIN) || (fmt_reg == FMT_PBM_RAW))
                               ? (fld >= 2'd1) : (fld >= 2'd2);
                    if (go && !last_hdr)
                    begin
                        if (is_ws(b))
                        begin
                            phase_next = ph_make(fld + 2'd1, 2'd1);
                        end
                        else if (b == CH_HASH)
                        begin
                            cm_next = 1'b1;
                            phase_next = ph_make(fld + 2'd1, 2'd0);
                        end
                        else
                        begin
                            err_next = ERR_NO_SPACE;
                            put = 1'b1;
                            rec.kind = RK_ERROR;
                            rec.err = ERR_NO_SPACE;
                        end
                    end
                    else if (go)
                    begin
                        if (is_ws(b) || ((b == CH_HASH) && (fmt_reg <= FMT_PPM_PLAIN)))
                        begin
                            if (b == CH_HASH)
                            begin
                                cm_next = 1'b1;
                            end
                            put = 1'b1;
                            rec.kind = RK_HEADER;
                            if ((w_next == 16'd0) || (h_next == 16'd0))
                            begin
                                phase_next = PH_MAGIC;
                                acc_next   = 16'd0;
                            end
                            else
                            begin
                                phase_next = PH_RASTER;
                            end
                            col_next  = 16'd0;
                            row_next  = 16'd0;
                            ch_next   = 2'd0;
                            ds_next   = 1'b0;
                            pend_next = 9'd0;
                        end
                        else
                        begin
                            err_next = ERR_NO_SPACE;
                            put = 1'b1;
                            rec.kind = RK_ERROR;
                            rec.err = ERR_NO_SPACE;
                        end
                    end
                end
            end
            else
            begin
                // header outside numbers: comments, magic, separators
                go = 1'b1;
                if (cm_reg)
                begin
                    if (b != CH_LF)
                    begin
                        go = 1'b0;
                    end
                    else
                    begin
                        cm_next = 1'b0;
                    end
                end
                else if (b == CH_HASH)
                begin
                    cm_next = 1'b1;
                    go = 1'b0;
                end
                if (go)
                begin
                    if (phase_reg == PH_MAGIC)
                    begin
                        if (b == CH_P)
                        begin
                            fmt_next = 3'd0;
                            w_next = 16'd0;
                            h_next = 16'd0;
                            m_next = 16'd0;
                            phase_next = PH_DIGIT;
                        end
                        else if (!is_ws(b))
                        begin
                            err_next = ERR_NO_P;
                            put = 1'b1;
                            rec.kind = RK_ERROR;
                            rec.err = ERR_NO_P;
                        end
                    end
                    else if (phase_reg == PH_DIGIT)
                    begin
                        if ((b >= CH_ONE) && (b < CH_SEVEN))
                        begin
                            fmt_next = b[2:0];
                            if ((b[2:0] == FMT_PBM_PLAIN) || (b[2:0] == FMT_PBM_RAW))
                            begin
                                m_next = 16'd1;
                            end
                            phase_next = PH_W_SEP;
                        end
                        else
                        begin
                            err_next = ERR_DIGIT;
                            put = 1'b1;
                            rec.kind = RK_ERROR;
                            rec.err = ERR_DIGIT;
                        end
                    end
                    else if (sub == 2'd0)
                    begin
                        if (is_ws(b))
                        begin
                            phase_next = ph_make(fld, 2'd1);
                        end
                        else
                        begin
                            err_next = ERR_NO_SPACE;
                            put = 1'b1;
                            rec.kind = RK_ERROR;
                            rec.err = ERR_NO_SPACE;
                        end
                    end
                    else if (is_digit(b))
                    begin
                        acc_next = {12'd0, b[3:0]};
                        phase_next = ph_make(fld, 2'd2);
                    end
                    else if (!is_ws(b))
                    begin
                        err_next = ERR_NUMBER;
                        put = 1'b1;
                        rec.kind = RK_ERROR;
                        rec.err = ERR_NUMBER;
                    end
                end
            end

            // end-of-file flush of a pending plain number
            if (!emit_req && item.end_of_file && (err_next == ERR_NONE)
                && (phase_next == PH_RASTER) && ds_next)
            begin
                emit_req = 1'b1;
                emit_val = acc_next;
                acc_next = 16'd0;
                ds_next = 1'b0;
            end

            // one sample and its position step
            if (emit_req)
            begin
                p = pos_advance(col_next, row_next, ch_next, spp, w_next, h_next);
                put = 1'b1;
                rec.kind  = RK_SAMPLE;
                rec.value = emit_val;
                rec.col   = col_next;
                rec.row   = row_next;
                rec.ch    = ch_next;
                rec.eoi   = p.eoi;
                col_next  = p.col;
                row_next  = p.row;
                ch_next   = p.ch;
                if (p.done)
                begin
                    phase_next = PH_MAGIC;
                    col_next   = 16'd0;
                    row_next   = 16'd0;
                    ch_next    = 2'd0;
                    ds_next    = 1'b0;
                    acc_next   = 16'd0;
                    pend_next  = 9'd0;
                end
            end

            // early end replaces everything else of this byte
            if (item.end_of_file && (err_next == ERR_NONE))
            begin
                if (phase_next != PH_MAGIC)
                begin
                    err_next = ERR_EARLY_END;
                    put = 1'b1;
                    rec = '0;
                    rec.kind = RK_ERROR;
                    rec.err = ERR_EARLY_END;
                end
                else
                begin
                    cm_next = 1'b0;
                end
            end
        end

        rec.fmt    = fmt_next;
        rec.width  = w_next;
        rec.height = h_next;
        rec.maxval = m_next;
    end

endmodule

// ----- rtl/pnm_fifo.sv -----
`timescale 1ns / 1ps

`include "pnm_image_stream_parser_top_macros.svh"

module pnm_fifo
    import pnm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  dsc_t push_data,
    input  logic pop,
    output dsc_t head,
    output logic empty,
    output logic full
);

    dsc_t                 mem [QDEPTH];
    logic [QPTR_BITS-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (QPTR_BITS+1)'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_reg];

    // pointer and fill updates
    always_comb
    begin
        wr_next    = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = do_pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    `PNM_ASSERT_ALWAYS(a_fill_bound, (!rst_n) || (count_reg <= (QPTR_BITS+1)'(QDEPTH)), "fill over depth")
    `PNM_ASSERT(a_pop_nonempty, pop |-> !empty, "job taken from empty queue")
    `PNM_ASSERT(a_ptr_gap, (wr_reg - rd_reg) == count_reg[QPTR_BITS-1:0], "pointers and fill disagree")

endmodule

// ----- rtl/pnm_back.sv -----
`timescale 1ns / 1ps

module pnm_back
    import pnm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  dsc_t    head,
    input  logic    empty,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_item
);

    logic [2:0] idx_reg, idx_next;
    logic       last, taken;

    assign result_valid = !empty;
    assign last  = (idx_reg == head.last_idx);
    assign taken = result_valid && !result_stall;
    assign pop   = taken && last;

    // position within a bit run
    always_comb
    begin
        idx_next = idx_reg;
        if (taken)
        begin
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 3'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // result fields from the job at the queue head
    always_comb
    begin
        result_item.result_kind  = head.kind;
        result_item.format_code  = head.fmt;
        result_item.image_width  = head.width;
        result_item.image_height = head.height;
        result_item.max_sample   = head.maxval;
        result_item.sample_value = head.is_bits ? {15'd0, head.bits[3'd7 - idx_reg]}
                                                : head.value;
        result_item.column       = head.col + {13'd0, idx_reg};
        result_item.row          = head.row;
        result_item.channel      = head.ch;
        result_item.error_code   = head.err;
        result_item.end_of_image = head.eoi && last;
        result_item.last_of_run  = last;
    end

endmodule

// ----- rtl/pnm_image_stream_parser_top.sv -----
`timescale 1ns / 1ps

// PNM (P1..P6) stream parser. Takes one file byte per cycle on the byte channel
// and gives header, sample and error items on the result channel. A byte is
// taken every cycle while the four-entry job queue has room; each byte yields at
// most one job, and the result side drains one item per cycle unless result_stall
// is high, so header and gray/colour bytes run at one per cycle while neither side
// stalls, and a raw bitmap byte gives one result item per pixel left in its row, up to eight.
// There is no clearing pass; the block is ready straight out of reset.
module pnm_image_stream_parser_top
    import pnm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    byte_valid,
    output logic    byte_stall,
    input  item_t   byte_item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_item
);

    logic full, empty, push, pop;
    dsc_t rec, head;

    assign byte_stall = full;

    pnm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (byte_valid && !full),
        .item  (byte_item),
        .push  (push),
        .rec   (rec)
    );

    pnm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (rec),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    pnm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule
